>>> src/aad_pkg.sv
// package for the asymmetric arctangent waveshaper
// widths, register codes, reset values and the cordic angle table; no dependencies
`timescale 1ns / 1ps

package aad_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int ATAN_ITER_DEF   = 16;
  localparam int ANGLE_STEPS     = 24;

  // register and datapath widths
  localparam int GAIN_W     = 24;
  localparam int DRIVE_W    = 16;
  localparam int NORM_W     = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int CLIP_W     = 7;
  localparam int V_W        = 31;   // pre-gained magnitude, Q.16, below 100 * 2^24
  localparam int ARG_W      = 47;   // atan argument, Q.24
  localparam int CW         = 50;   // cordic x / y
  localparam int ZW         = 33;   // cordic angle, signed Q2.30
  localparam int TH_W       = 31;   // clamped angle
  localparam int NORM_SHIFT_BASE = 46;  // 30 angle + 16 norm fraction bits
  localparam int LVL_FRAC   = 16;

  localparam logic [CLIP_W-1:0] CLIP_GAIN = 7'd100;
  localparam logic signed [CW-1:0] X_INIT = 50'sd16777216;

  localparam logic [GAIN_W-1:0]  PRE_GAIN_RST  = 24'd65536;
  localparam logic [GAIN_W-1:0]  OUT_LEVEL_RST = 24'd65536;
  localparam logic [DRIVE_W-1:0] DRIVE_POS_RST = 16'd1280;
  localparam logic [DRIVE_W-1:0] DRIVE_NEG_RST = 16'd640;
  localparam logic [NORM_W-1:0]  NORM_POS_RST  = 20'd47717;
  localparam logic [NORM_W-1:0]  NORM_NEG_RST  = 20'd27530;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRE_GAIN  = 3'd0,
    REG_OUT_LEVEL = 3'd1,
    REG_DRIVE_POS = 3'd2,
    REG_DRIVE_NEG = 3'd3,
    REG_NORM_POS  = 3'd4,
    REG_NORM_NEG  = 3'd5
  } cfg_reg_t;

  // side information that rides along with the cordic pipeline
  typedef struct packed {
    logic neg;
    logic zero;
  } aad_tag_t;

  typedef logic [31:0] angle_tab_t [ANGLE_STEPS];

  // round(atan(2^-i) * 2^30)
  localparam angle_tab_t ANGLE_TAB = '{
    32'd843314857, 32'd497837830, 32'd263043837, 32'd133525159,
    32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
    32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
    32'd262144,    32'd131072,    32'd65536,     32'd32768,
    32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128
  };

endpackage

>>> src/asymmetric_atan_distortion_top.sv
// top level of the asymmetric arctangent waveshaper: config registers and gain pipeline
// depends on aad_pkg and aad_cordic
`timescale 1ns / 1ps

// Usage
//   A request is taken at each rising edge where start is high and busy is low.
//   busy is high through reset and the cycle after it; afterwards a new sample may be
//   presented every cycle.
//   Each result shows on out_sample_out / out_saturated for exactly one cycle
//   with out_valid high; the receiver has no way to stall and must take it.
//   Iterations above 24 count as 24. There are four stages of gain and magnitude
//   work, one stage per cordic iteration, then angle clamp, normalize, output
//   level and saturation. Throughput is one sample per cycle; each cordic
//   iteration has its own stage.
//   Configuration writes use cfg_valid / cfg_ready (always ready), cfg_index and
//   cfg_data; indexes above 5 are dropped. Registers should only change while no
//   samples are in flight.
//   Synchronous reset clears all valid bits, so anything in flight is discarded,
//   and loads the default register values.
module asymmetric_atan_distortion_top #(
  parameter int SAMPLE_BITS     = aad_pkg::SAMPLE_BITS_DEF,
  parameter int ATAN_ITERATIONS = aad_pkg::ATAN_ITER_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample_in,
  output logic                                out_valid,
  output logic signed [SAMPLE_BITS-1:0]       out_sample_out,
  output logic                                out_saturated,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [aad_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [aad_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import aad_pkg::*;

  localparam int FRAC    = SAMPLE_BITS - 1;
  localparam int NSTEP   = (ATAN_ITERATIONS > ANGLE_STEPS) ? ANGLE_STEPS : ATAN_ITERATIONS;
  localparam int LATENCY = NSTEP + 8;
  localparam int P1_W    = SAMPLE_BITS + GAIN_W;
  localparam int P2_W    = P1_W + CLIP_W;
  localparam int TN_W    = TH_W + NORM_W;
  localparam int S_SHIFT = NORM_SHIFT_BASE - FRAC;
  localparam int S_W     = TN_W - S_SHIFT;
  localparam int SL_W    = S_W + GAIN_W;
  localparam int O_W     = SL_W - LVL_FRAC;

  // configuration registers
  logic [GAIN_W-1:0]  pre_gain_r, out_level_r;
  logic [DRIVE_W-1:0] drive_pos_r, drive_neg_r;
  logic [NORM_W-1:0]  norm_pos_r, norm_neg_r;
  logic               busy_r;

  assign cfg_ready = 1'b1;
  assign busy      = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_gain_r  <= PRE_GAIN_RST;
      out_level_r <= OUT_LEVEL_RST;
      drive_pos_r <= DRIVE_POS_RST;
      drive_neg_r <= DRIVE_NEG_RST;
      norm_pos_r  <= NORM_POS_RST;
      norm_neg_r  <= NORM_NEG_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PRE_GAIN:  pre_gain_r  <= cfg_data[GAIN_W-1:0];
        REG_OUT_LEVEL: out_level_r <= cfg_data[GAIN_W-1:0];
        REG_DRIVE_POS: drive_pos_r <= cfg_data[DRIVE_W-1:0];
        REG_DRIVE_NEG: drive_neg_r <= cfg_data[DRIVE_W-1:0];
        REG_NORM_POS:  norm_pos_r  <= cfg_data[NORM_W-1:0];
        REG_NORM_NEG:  norm_neg_r  <= cfg_data[NORM_W-1:0];
        default: ;
      endcase
    end
  end

  // held high through reset and the cycle after it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // valid bits of the gain and output stages
  logic vld1_r, vld2_r, vld3_r, vld4_r, vldt_r, vlds_r, vldo_r, out_valid_r;
  logic cor_vld;
  logic accept;

  assign accept = start && !busy_r;

  // payload registers
  logic                     neg1_r, neg2_r, neg3_r, neg4_r, negt_r, negs_r, nego_r;
  logic [SAMPLE_BITS-1:0]   mag1_r;
  logic [P1_W-1:0]          p1_r;
  logic [V_W-1:0]           v_r;
  logic [ARG_W-1:0]         arg_r;
  logic [TH_W-1:0]          th_r;
  logic [S_W-1:0]           s_r;
  logic [O_W-1:0]           o_r;
  logic [SAMPLE_BITS-1:0]   out_sample_r;
  logic                     out_sat_r;

  logic [SAMPLE_BITS-1:0]   mag1_nxt;
  logic [P1_W-1:0]          p1_nxt;
  logic [P2_W-1:0]          p2;
  logic [V_W-1:0]           v_nxt;
  logic [ARG_W-1:0]         arg_nxt;
  logic [DRIVE_W-1:0]       drive_sel;
  logic [NORM_W-1:0]        norm_sel;
  logic [TH_W-1:0]          th_nxt;
  logic [TN_W-1:0]          tn_prod;
  logic [S_W-1:0]           s_nxt;
  logic [SL_W-1:0]          sl_prod;
  logic [O_W-1:0]           o_nxt;
  logic [O_W-1:0]           limit;
  logic [O_W-1:0]           o_clamp;
  logic [O_W-1:0]           o_signed;
  logic                     sat_nxt;

  aad_tag_t                 cor_in_tag_w, cor_out_tag;
  logic signed [ZW-1:0]     cor_angle;

  // the negative full-scale sample maps to magnitude 2^FRAC, still fits
  assign mag1_nxt = in_sample_in[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - $unsigned(in_sample_in))
                                                : $unsigned(in_sample_in);
  assign p1_nxt    = P1_W'(mag1_r) * P1_W'(pre_gain_r);
  assign p2        = P2_W'(p1_r) * P2_W'(CLIP_GAIN);
  assign v_nxt     = V_W'(p2 >> FRAC);
  assign drive_sel = neg3_r ? drive_neg_r : drive_pos_r;
  assign arg_nxt   = ARG_W'(v_r) * ARG_W'(drive_sel);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r      <= 1'b0;
      vld2_r      <= 1'b0;
      vld3_r      <= 1'b0;
      vld4_r      <= 1'b0;
      vldt_r      <= 1'b0;
      vlds_r      <= 1'b0;
      vldo_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld1_r      <= accept;
      vld2_r      <= vld1_r;
      vld3_r      <= vld2_r;
      vld4_r      <= vld3_r;
      vldt_r      <= cor_vld;
      vlds_r      <= vldt_r;
      vldo_r      <= vlds_r;
      out_valid_r <= vldo_r;
    end
  end

  // gain stages
  always_ff @(posedge clk) begin
    neg1_r <= in_sample_in[SAMPLE_BITS-1];
    mag1_r <= mag1_nxt;
    neg2_r <= neg1_r;
    p1_r   <= p1_nxt;
    neg3_r <= neg2_r;
    v_r    <= v_nxt;
    neg4_r <= neg3_r;
    arg_r  <= arg_nxt;
  end

  assign cor_in_tag_w.neg  = neg4_r;
  assign cor_in_tag_w.zero = (arg_r == '0);

  aad_cordic #(
    .ITERATIONS (ATAN_ITERATIONS)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (vld4_r),
    .in_tag    (cor_in_tag_w),
    .in_arg    (arg_r),
    .out_vld   (cor_vld),
    .out_tag   (cor_out_tag),
    .out_angle (cor_angle)
  );

  // a zero argument short-cuts the cordic to angle 0, and a negative angle is clamped to 0
  assign th_nxt   = (cor_out_tag.zero || cor_angle[ZW-1]) ? '0 : cor_angle[TH_W-1:0];
  assign norm_sel = negt_r ? norm_neg_r : norm_pos_r;
  assign tn_prod  = TN_W'(th_r) * TN_W'(norm_sel);
  assign s_nxt    = S_W'(tn_prod >> S_SHIFT);
  assign sl_prod  = SL_W'(s_r) * SL_W'(out_level_r);
  assign o_nxt    = O_W'(sl_prod >> LVL_FRAC);

  // negative side may reach full scale, positive side stops one short
  assign limit    = nego_r ? (O_W'(1) << FRAC) : ((O_W'(1) << FRAC) - O_W'(1));
  assign sat_nxt  = o_r > limit;
  assign o_clamp  = sat_nxt ? limit : o_r;
  assign o_signed = nego_r ? (~o_clamp + O_W'(1)) : o_clamp;

  always_ff @(posedge clk) begin
    negt_r       <= cor_out_tag.neg;
    th_r         <= th_nxt;
    negs_r       <= negt_r;
    s_r          <= s_nxt;
    nego_r       <= negs_r;
    o_r          <= o_nxt;
    out_sample_r <= o_signed[SAMPLE_BITS-1:0];
    out_sat_r    <= sat_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = $signed(out_sample_r);
  assign out_saturated  = out_sat_r;

  // every result goes back to exactly one earlier request
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, LATENCY))
  else $error("result strobe without a matching request");

  // a clamped result sits on one of the two full-scale codes
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_sample_out == {1'b0, {(SAMPLE_BITS-1){1'b1}}} ||
       out_sample_out == {1'b1, {(SAMPLE_BITS-1){1'b0}}}))
  else $error("saturation flag on an unclamped result");

  // a zero sample comes out as zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(start && !busy && rst_n && (in_sample_in == '0), LATENCY)) |->
      (out_sample_out == '0 && !out_saturated))
  else $error("zero sample did not give zero result");

endmodule

>>> src/aad_cordic.sv
// pipelined cordic vectoring unit, one register stage per iteration
// depends on aad_pkg for widths, the tag struct and the angle table
`timescale 1ns / 1ps

module aad_cordic #(
  parameter int ITERATIONS = aad_pkg::ATAN_ITER_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_vld,
  input  aad_pkg::aad_tag_t                   in_tag,
  input  logic [aad_pkg::ARG_W-1:0]           in_arg,
  output logic                                out_vld,
  output aad_pkg::aad_tag_t                   out_tag,
  output logic signed [aad_pkg::ZW-1:0]       out_angle
);
  import aad_pkg::*;

  localparam int NSTEP = (ITERATIONS > ANGLE_STEPS) ? ANGLE_STEPS : ITERATIONS;

  logic signed [CW-1:0] x_r [NSTEP];
  logic signed [CW-1:0] y_r [NSTEP];
  logic signed [ZW-1:0] z_r [NSTEP];
  logic                 vld_r [NSTEP];
  aad_tag_t             tag_r [NSTEP];

  // arithmetic shift that truncates toward zero
  function automatic logic signed [CW-1:0] shr_tz(input logic signed [CW-1:0] v,
                                                  input int s);
    logic [CW-1:0] mag;
    mag = v[CW-1] ? $unsigned(-v) : $unsigned(v);
    mag = mag >> s;
    return v[CW-1] ? -$signed(mag) : $signed(mag);
  endfunction

  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    logic signed [CW-1:0] xi, yi, dx, dy;
    logic signed [ZW-1:0] zi, ang;
    logic                 vi;
    aad_tag_t             ti;

    if (i == 0) begin : g_first
      assign xi = X_INIT;
      assign yi = $signed({{(CW-ARG_W){1'b0}}, in_arg});
      assign zi = '0;
      assign vi = in_vld;
      assign ti = in_tag;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign vi = vld_r[i-1];
      assign ti = tag_r[i-1];
    end

    assign dx  = shr_tz(yi, i);
    assign dy  = shr_tz(xi, i);
    assign ang = $signed({1'b0, ANGLE_TAB[i]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      tag_r[i] <= ti;
      if (yi > 0) begin
        x_r[i] <= xi + dx;
        y_r[i] <= yi - dy;
        z_r[i] <= zi + ang;
      end else begin
        x_r[i] <= xi - dx;
        y_r[i] <= yi + dy;
        z_r[i] <= zi - ang;
      end
    end
  end

  assign out_vld   = vld_r[NSTEP-1];
  assign out_tag   = tag_r[NSTEP-1];
  assign out_angle = z_r[NSTEP-1];

endmodule

>>> sim/tb.sv
// testbench for the asymmetric arctangent waveshaper: drives samples and register writes,
// predicts every shaped sample and checks it against the block; depends on aad_pkg
`timescale 1ns / 1ps

module tb;

  localparam int SAMPLE_W        = 24;
  localparam int ATAN_ITERATIONS = 16;
  localparam int CORDIC_STEPS    = (ATAN_ITERATIONS > 24) ? 24 : ATAN_ITERATIONS;
  localparam int LATENCY         = CORDIC_STEPS + 8;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int GAP_MAX         = 17;

  localparam logic [aad_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [aad_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  // atan(2^-i) in Q2.30, rounded
  localparam longint ARCTAN_STEP [0:23] = '{
    843314857, 497837830, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128
  };

  typedef struct {
    logic [SAMPLE_W-1:0] sample_out;
    logic                saturated;
  } shaped_t;

  class shaper_scoreboard;
    logic [63:0] pre_gain, out_level, drive_pos, drive_neg, norm_pos, norm_neg;
    shaped_t     shaped_q[$];
    int          fail_count;

    function new();
      pre_gain   = 64'd65536;
      out_level  = 64'd65536;
      drive_pos  = 64'd1280;
      drive_neg  = 64'd640;
      norm_pos   = 64'd47717;
      norm_neg   = 64'd27530;
      fail_count = 0;
    endfunction

    function void write_reg(logic [aad_pkg::CFG_IDX_W-1:0] idx,
                            logic [aad_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        aad_pkg::REG_PRE_GAIN:  pre_gain  = 64'(data);
        aad_pkg::REG_OUT_LEVEL: out_level = 64'(data);
        aad_pkg::REG_DRIVE_POS: drive_pos = 64'(data[15:0]);
        aad_pkg::REG_DRIVE_NEG: drive_neg = 64'(data[15:0]);
        aad_pkg::REG_NORM_POS:  norm_pos  = 64'(data[19:0]);
        aad_pkg::REG_NORM_NEG:  norm_neg  = 64'(data[19:0]);
        default: ;
      endcase
    endfunction

    // shift toward zero, also for negative values
    function longint trunc_shift(longint v, int sh);
      return (v < 0) ? -((-v) >>> sh) : (v >>> sh);
    endfunction

    function logic [63:0] arctan_q30(logic [63:0] arg);
      longint x, y, z, dx, dy;
      if (arg == 64'd0) return 64'd0;
      x = 64'sd16777216;
      y = longint'(arg);
      z = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = trunc_shift(y, i);
        dy = trunc_shift(x, i);
        if (y > 0) begin
          x = x + dx;
          y = y - dy;
          z = z + ARCTAN_STEP[i];
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - ARCTAN_STEP[i];
        end
      end
      return (z < 0) ? 64'd0 : 64'(z);
    endfunction

    function shaped_t shape_sample(logic [SAMPLE_W-1:0] raw);
      shaped_t     res;
      logic        neg;
      logic [63:0] mag, drive, norm, v, arg, th, s, o, lim;
      neg   = raw[SAMPLE_W-1];
      mag   = neg ? ((64'd1 << SAMPLE_W) - 64'(raw)) : 64'(raw);
      drive = neg ? drive_neg : drive_pos;
      norm  = neg ? norm_neg : norm_pos;
      v     = (mag * pre_gain * 64'd100) >> (SAMPLE_W - 1);
      arg   = v * drive;
      th    = arctan_q30(arg);
      s     = (th * norm) >> (46 - (SAMPLE_W - 1));
      o     = (s * out_level) >> 16;
      lim   = neg ? (64'd1 << (SAMPLE_W - 1)) : ((64'd1 << (SAMPLE_W - 1)) - 64'd1);
      res.saturated = 1'b0;
      if (o > lim) begin
        o = lim;
        res.saturated = 1'b1;
      end
      res.sample_out = neg ? SAMPLE_W'((64'd1 << SAMPLE_W) - o) : SAMPLE_W'(o);
      return res;
    endfunction

    function void note_input(logic [SAMPLE_W-1:0] smp);
      shaped_q.push_back(shape_sample(smp));
    endfunction

    function void check_result(logic [SAMPLE_W-1:0] smp, logic sat);
      shaped_t exp_r;
      if (shaped_q.size() == 0) begin
        $error("result with no request pending: sample_out %0d saturated %0b",
               $signed(smp), sat);
        fail_count++;
        return;
      end
      exp_r = shaped_q.pop_front();
      if (exp_r.sample_out !== smp) begin
        $error("sample_out: expected %0d, actual %0d", $signed(exp_r.sample_out),
               $signed(smp));
        fail_count++;
      end
      if (exp_r.saturated !== sat) begin
        $error("saturated: expected %0b, actual %0b", exp_r.saturated, sat);
        fail_count++;
      end
    endfunction

    function int pending();
      return shaped_q.size();
    endfunction
  endclass

  logic                               clk;
  logic                               rst_n;
  logic                               start;
  logic                               busy;
  logic signed [SAMPLE_W-1:0]         in_sample_in;
  logic                               out_valid;
  logic signed [SAMPLE_W-1:0]         out_sample_out;
  logic                               out_saturated;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [aad_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [aad_pkg::CFG_DATA_W-1:0]     cfg_data;

  shaper_scoreboard shaper_sb;
  int               cycle_count;
  logic             burst_mode;

  asymmetric_atan_distortion_top #(
    .SAMPLE_BITS(SAMPLE_W),
    .ATAN_ITERATIONS(ATAN_ITERATIONS)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_sample_in(in_sample_in),
    .out_valid(out_valid),
    .out_sample_out(out_sample_out),
    .out_saturated(out_saturated),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) shaper_sb.check_result(out_sample_out, out_saturated);
  end

  // caller is at a falling edge; leaves start high for the next request
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start        <= 1'b1;
    in_sample_in <= smp;
    do @(posedge clk); while (busy);
    shaper_sb.note_input(smp);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [aad_pkg::CFG_IDX_W-1:0] idx,
                           input logic [aad_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    shaper_sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (shaper_sb.pending() > 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_all(input logic [23:0] pg, input logic [23:0] ol,
                           input logic [23:0] dp, input logic [23:0] dn,
                           input logic [23:0] np, input logic [23:0] nn);
    write_reg(aad_pkg::REG_PRE_GAIN, pg);
    write_reg(aad_pkg::REG_OUT_LEVEL, ol);
    write_reg(aad_pkg::REG_DRIVE_POS, dp);
    write_reg(aad_pkg::REG_DRIVE_NEG, dn);
    write_reg(aad_pkg::REG_NORM_POS, np);
    write_reg(aad_pkg::REG_NORM_NEG, nn);
    cfg_valid <= 1'b0;
  endtask

  function automatic int draw_gap();
    if ($urandom_range(0, 15) == 0) burst_mode = ~burst_mode;
    return burst_mode ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    logic [SAMPLE_W-1:0] mag;
    mag = '0;
    case ($urandom_range(0, 3))
      0: return SAMPLE_W'($urandom);
      1: begin
        // small magnitudes land on the curved part of the shaper
        mag = SAMPLE_W'($urandom_range(0, 1 << $urandom_range(0, 20)));
        return ($urandom_range(0, 1) != 0) ? -mag : mag;
      end
      2: begin
        case ($urandom_range(0, 4))
          0: return 24'h7FFFFF;
          1: return 24'h800000;
          2: return 24'h000000;
          3: return 24'h000001;
          default: return 24'hFFFFFF;
        endcase
      end
      default: begin
        mag = SAMPLE_W'($urandom_range(0, 24'h7FFFFF));
        return ($urandom_range(0, 1) != 0) ? -mag : mag;
      end
    endcase
  endfunction

  function automatic logic [23:0] rand_gain();
    return 24'($urandom_range(0, (1 << $urandom_range(0, 24)) - 1));
  endfunction

  function automatic logic [23:0] rand_drive();
    if ($urandom_range(0, 3) == 0) return 24'($urandom);
    return 24'($urandom_range(1, (1 << $urandom_range(1, 16)) - 1));
  endfunction

  function automatic logic [23:0] rand_norm();
    if ($urandom_range(0, 3) == 0) return 24'($urandom);
    return 24'($urandom_range(0, 20'hFFFFF));
  endfunction

  task automatic run_random(input int n, input bool_pause);
    for (int i = 0; i < n; i++) begin
      if (bool_pause && i == n / 2) drain();
      send_sample(rand_sample(), draw_gap());
    end
  endtask

  initial begin
    logic [SAMPLE_W-1:0] directed_q[$];
    shaper_sb    = new();
    cycle_count  = 0;
    burst_mode   = 1'b1;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_sample_in = '0;
    cfg_valid    = 1'b0;
    cfg_index    = aad_pkg::REG_PRE_GAIN;
    cfg_data     = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: zero, unit steps, full scale, the knee region
    directed_q = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h000002, 24'hFFFFFE,
                   24'h7FFFFF, 24'h800000, 24'h0147AE, 24'hFEB852, 24'h000346,
                   24'hFFFCBA, 24'h0020C4, 24'hFFDF3C, 24'h00A3D7, 24'hFF5C29,
                   24'h0001F4, 24'hFFFE0C, 24'h400000, 24'hC00000, 24'h555555,
                   24'hAAAAAA};
    foreach (directed_q[i]) send_sample(directed_q[i], (i < 10) ? 0 : draw_gap());
    run_random(60, 1'b1);

    // largest gains and norms, smallest steepness; unused indexes are dropped
    drain();
    write_reg(REG_UNUSED_LO, 24'hFFFFFF);
    write_reg(REG_UNUSED_HI, 24'h000000);
    write_all(24'hFFFFFF, 24'hFFFFFF, 24'h000001, 24'h000001, 24'h0FFFFF, 24'h0FFFFF);
    foreach (directed_q[i]) if (i < 7) send_sample(directed_q[i], 0);
    run_random(35, 1'b0);

    // zero pre-gain gives a zero argument
    drain();
    write_all(24'h000000, 24'h010000, 24'h000500, 24'h000280, 24'h00BA65, 24'h006B8A);
    run_random(30, 1'b0);

    // steepest drive with zero norm and zero level
    drain();
    write_all(24'h010000, 24'h000000, 24'h00FFFF, 24'h00FFFF, 24'h000000, 24'h000000);
    run_random(30, 1'b0);

    // upper data bits are masked off: drive becomes zero
    drain();
    write_all(24'h0A0000, 24'h020000, 24'hAB0000, 24'hFF0000, 24'hF0BA65, 24'h5F6B8A);
    run_random(30, 1'b0);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_all(rand_gain(), rand_gain(), rand_drive(), rand_drive(), rand_norm(),
                rand_norm());
      if ($urandom_range(0, 1) != 0) begin
        write_reg(($urandom_range(0, 1) != 0) ? REG_UNUSED_LO : REG_UNUSED_HI,
                  24'($urandom));
        cfg_valid <= 1'b0;
      end
      burst_mode = (ph % 2 == 0);
      run_random(55, ph == 3);
    end

    drain();
    if (shaper_sb.fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
src/aad_pkg.sv
src/aad_cordic.sv
src/asymmetric_atan_distortion_top.sv
sim/tb.sv
